FILE: hdl/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message text tokenizer package
// Result codes, word classes, float recogniser states and the result record
// shared by the tokenizer, its checker and the testbench.
// ----------------------------------------------------------------------------
package mtt_pkg;

	// Field widths of the channels.
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int CLASS_W = 2;
	localparam int INDEX_W = 16;
	localparam int LEN_W = 11;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEMI = 2'd2;
	localparam logic [KIND_W-1:0] KIND_COMMA = 2'd3;

	// Word classes reported at word end.
	localparam logic [CLASS_W-1:0] CLS_SYMBOL = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_FLOAT = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_DOLLAR_NUM = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_DOLLAR_SYM = 2'd3;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_E_LOW = 8'h65;
	localparam logic [CHAR_W-1:0] CH_E_UP = 8'h45;
	localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;

	// Saturation limit of the dollar index.
	localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

	// Float recogniser states.
	localparam int NS_W = 4;
	localparam logic [NS_W-1:0] NS_START = 4'd0;
	localparam logic [NS_W-1:0] NS_MINUS = 4'd1;
	localparam logic [NS_W-1:0] NS_INT = 4'd2;
	localparam logic [NS_W-1:0] NS_LEAD_DOT = 4'd3;
	localparam logic [NS_W-1:0] NS_DOT = 4'd4;
	localparam logic [NS_W-1:0] NS_FRAC = 4'd5;
	localparam logic [NS_W-1:0] NS_EXP = 4'd6;
	localparam logic [NS_W-1:0] NS_EXP_SIGN = 4'd7;
	localparam logic [NS_W-1:0] NS_EXP_DIGIT = 4'd8;
	localparam logic [NS_W-1:0] NS_ERROR = 4'd9;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  ch;
		logic [CLASS_W-1:0] cls;
		logic [INDEX_W-1:0] idx;
		logic [LEN_W-1:0]   len;
		logic               last;
	} result_t;

	// Decimal digit test.
	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c inside {[CH_ZERO:CH_NINE]});
	endfunction

	// Next state of the decimal float recogniser.
	function automatic logic [NS_W-1:0] float_next(input logic [NS_W-1:0] s,
	                                               input logic [CHAR_W-1:0] c);
		logic dg;
		logic dt;
		logic mn;
		logic pl;
		logic ex;
		logic [NS_W-1:0] n;
		dg = is_digit(c);
		dt = (c == CH_DOT);
		mn = (c == CH_MINUS);
		pl = (c == CH_PLUS);
		ex = (c == CH_E_LOW) || (c == CH_E_UP);
		n = NS_ERROR;
		case (s)
			NS_START: begin
				if (mn) n = NS_MINUS;
				else if (dg) n = NS_INT;
				else if (dt) n = NS_LEAD_DOT;
			end
			NS_MINUS: begin
				if (dg) n = NS_INT;
				else if (dt) n = NS_LEAD_DOT;
			end
			NS_INT: begin
				if (dt) n = NS_DOT;
				else if (ex) n = NS_EXP;
				else if (dg) n = NS_INT;
			end
			NS_LEAD_DOT: begin
				if (dg) n = NS_FRAC;
			end
			NS_DOT: begin
				if (dg) n = NS_FRAC;
				else if (ex) n = NS_EXP;
			end
			NS_FRAC: begin
				if (ex) n = NS_EXP;
				else if (dg) n = NS_FRAC;
			end
			NS_EXP: begin
				if (pl || mn) n = NS_EXP_SIGN;
				else if (dg) n = NS_EXP_DIGIT;
			end
			NS_EXP_SIGN: begin
				if (dg) n = NS_EXP_DIGIT;
			end
			NS_EXP_DIGIT: begin
				if (dg) n = NS_EXP_DIGIT;
			end
			default: begin
				n = NS_ERROR;
			end
		endcase
		return n;
	endfunction

endpackage

FILE: hdl/message_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message text tokenizer
// Splits message text into word characters, word ends with their class
// (symbol, float, dollar number, dollar symbol), semicolons and commas.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | char_code, end_of_text
//  out     | out_valid/out_ready| result_kind, char_value, word_class,
//          |                    | dollar_index, word_length, last_of_run
//
// One character is taken per cycle; its zero, one or two results are written
// into a four-entry result queue in the same cycle and appear on the output
// from the next cycle on, one per cycle while out_ready is high.
// A character is taken only while the queue has room for two results, so a
// stalled output stops the input as soon as three or more results are waiting.
// Reset puts the tokenizer outside a word with an empty queue.
// ----------------------------------------------------------------------------
module message_text_tokenizer_unit #(
	parameter int unsigned MAX_WORD = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mtt_pkg::CHAR_W-1:0]    char_code,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtt_pkg::KIND_W-1:0]    result_kind,
	output logic [mtt_pkg::CHAR_W-1:0]    char_value,
	output logic [mtt_pkg::CLASS_W-1:0]   word_class,
	output logic [mtt_pkg::INDEX_W-1:0]   dollar_index,
	output logic [mtt_pkg::LEN_W-1:0]     word_length,
	output logic                          last_of_run
);
	import mtt_pkg::*;

	localparam int CW = $clog2(MAX_WORD + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORD);

	// Tokenizer state.
	logic               inside_q;
	logic [NS_W-1:0]    nstate_q;
	logic               esc_q;
	logic               pend_q;
	logic               seen_q;
	logic               digits_q;
	logic [INDEX_W-1:0] acc_q;
	logic [CW-1:0]      kept_q;

	// Next state and results of the current character.
	logic               inside_d;
	logic [NS_W-1:0]    nstate_d;
	logic               esc_d;
	logic               pend_d;
	logic               seen_d;
	logic               digits_d;
	logic [INDEX_W-1:0] acc_d;
	logic [CW-1:0]      kept_d;
	result_t            res0;
	result_t            res1;
	logic [1:0]         n_res;

	// Result queue.
	result_t            queue_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	logic in_fire;
	logic out_fire;

	assign in_ready = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Character classification, state update and result forming.
	always_comb begin
		logic sp;
		logic sep;
		logic dg;
		logic [KIND_W-1:0] sep_kind;
		logic b_esc;
		logic b_pend;
		logic b_seen;
		logic b_digits;
		logic [INDEX_W-1:0] b_acc;
		logic [CW-1:0] b_kept;
		logic [NS_W-1:0] b_ns;
		logic [19:0] prod;
		logic kept_byte;
		logic fin;
		result_t end_res;
		result_t sep_res;
		result_t chr_res;

		sp = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
		     (char_code == CH_LF) || (char_code == CH_CR);
		sep = (char_code == CH_SEMI) || (char_code == CH_COMMA);
		dg = is_digit(char_code);
		sep_kind = (char_code == CH_SEMI) ? KIND_SEMI : KIND_COMMA;

		sep_res = '0;
		sep_res.kind = sep_kind;
		sep_res.last = 1'b1;

		// A fresh word starts from cleared state.
		b_esc = inside_q ? esc_q : 1'b0;
		b_pend = inside_q ? pend_q : 1'b0;
		b_seen = inside_q ? seen_q : 1'b0;
		b_digits = inside_q ? digits_q : 1'b0;
		b_acc = inside_q ? acc_q : '0;
		b_kept = inside_q ? kept_q : '0;
		b_ns = inside_q ? nstate_q : NS_START;

		// Word path update.
		nstate_d = (b_ns != NS_ERROR) ? float_next(b_ns, char_code) : b_ns;
		seen_d = b_seen || (b_pend && dg);
		pend_d = !b_esc && (char_code == CH_DOLLAR);
		kept_byte = !(!b_esc && (char_code == CH_BSLASH));
		esc_d = !kept_byte;
		digits_d = b_digits;
		acc_d = b_acc;
		prod = {1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0} +
		       {12'd0, char_code - CH_ZERO};
		kept_d = b_kept;
		if (kept_byte) begin
			if (b_kept == '0) begin
				digits_d = (char_code == CH_DOLLAR);
			end else if (b_digits) begin
				if (dg) begin
					acc_d = (prod > 20'(INDEX_MAX)) ? INDEX_MAX : prod[INDEX_W-1:0];
				end else begin
					digits_d = 1'b0;
				end
			end
			kept_d = b_kept + 1'b1;
		end
		fin = end_of_text || (kept_d >= MAX_CNT);

		chr_res = '0;
		chr_res.kind = KIND_CHAR;
		chr_res.ch = char_code;

		// Word end record from either the held or the updated state.
		end_res = '0;
		end_res.kind = KIND_END;
		inside_d = inside_q;
		res0 = '0;
		res1 = '0;
		n_res = 2'd0;

		if (inside_q && !esc_q && (sp || sep)) begin
			// Word closed by whitespace or a separator.
			if ((nstate_q == NS_INT) || (nstate_q == NS_DOT) ||
			    (nstate_q == NS_FRAC) || (nstate_q == NS_EXP_DIGIT)) begin
				end_res.cls = CLS_FLOAT;
			end else if (seen_q) begin
				end_res.cls = digits_q ? CLS_DOLLAR_NUM : CLS_DOLLAR_SYM;
				end_res.idx = digits_q ? acc_q : '0;
			end
			end_res.len = LEN_W'(kept_q);
			end_res.last = !sep;
			res0 = end_res;
			res1 = sep_res;
			n_res = sep ? 2'd2 : 2'd1;
			inside_d = 1'b0;
		end else if (!inside_q && sp) begin
			n_res = 2'd0;
		end else if (!inside_q && sep) begin
			res0 = sep_res;
			n_res = 2'd1;
		end else begin
			// Character taken into a word.
			if ((nstate_d == NS_INT) || (nstate_d == NS_DOT) ||
			    (nstate_d == NS_FRAC) || (nstate_d == NS_EXP_DIGIT)) begin
				end_res.cls = CLS_FLOAT;
			end else if (seen_d) begin
				end_res.cls = digits_d ? CLS_DOLLAR_NUM : CLS_DOLLAR_SYM;
				end_res.idx = digits_d ? acc_d : '0;
			end
			end_res.len = LEN_W'(kept_d);
			end_res.last = 1'b1;
			inside_d = !fin;
			if (kept_byte) begin
				chr_res.last = !fin;
				res0 = chr_res;
				res1 = end_res;
				n_res = fin ? 2'd2 : 2'd1;
			end else begin
				res0 = end_res;
				n_res = fin ? 2'd1 : 2'd0;
			end
		end
	end

	// Tokenizer state registers; a word that is left returns to cleared state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			nstate_q <= NS_START;
			esc_q <= 1'b0;
			pend_q <= 1'b0;
			seen_q <= 1'b0;
			digits_q <= 1'b0;
			acc_q <= '0;
			kept_q <= '0;
		end else if (in_fire) begin
			inside_q <= inside_d;
			if (inside_d) begin
				nstate_q <= nstate_d;
				esc_q <= esc_d;
				pend_q <= pend_d;
				seen_q <= seen_d;
				digits_q <= digits_d;
				acc_q <= acc_d;
				kept_q <= kept_d;
			end else begin
				nstate_q <= NS_START;
				esc_q <= 1'b0;
				pend_q <= 1'b0;
				seen_q <= 1'b0;
				digits_q <= 1'b0;
				acc_q <= '0;
				kept_q <= '0;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (in_fire && (n_res != 2'd0)) begin
			queue_q[wr_q] <= res0;
		end
		if (in_fire && (n_res == 2'd2)) begin
			queue_q[wr_q + 1'b1] <= res1;
		end
	end

	// Result queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_fire) begin
				wr_q <= wr_q + QPTR_W'(n_res);
			end
			if (out_fire) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (in_fire ? QCNT_W'(n_res) : '0) -
			         QCNT_W'(out_fire);
		end
	end

	// Head of the queue drives the output transfer.
	assign out_valid = (cnt_q != '0);
	assign result_kind = queue_q[rd_q].kind;
	assign char_value = queue_q[rd_q].ch;
	assign word_class = queue_q[rd_q].cls;
	assign dollar_index = queue_q[rd_q].idx;
	assign word_length = queue_q[rd_q].len;
	assign last_of_run = queue_q[rd_q].last;

endmodule

FILE: hdl/mtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message text tokenizer checker
// Port-level checks of the result stream, bound to the tokenizer top level.
// ----------------------------------------------------------------------------
module mtt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mtt_pkg::KIND_W-1:0]    result_kind,
	input logic [mtt_pkg::CLASS_W-1:0]   word_class,
	input logic [mtt_pkg::INDEX_W-1:0]   dollar_index,
	input logic [mtt_pkg::LEN_W-1:0]     word_length,
	input logic                          last_of_run
);
	import mtt_pkg::*;

	// A result that is offered stays offered until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// Word fields are zero on every result other than a word end.
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_END) |->
		(word_class == CLS_SYMBOL) && (dollar_index == '0) && (word_length == '0))
		else $error("word fields set on a result that is not a word end");

	// Only a dollar number carries an index.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (word_class != CLS_DOLLAR_NUM) |-> (dollar_index == '0))
		else $error("dollar index set outside the dollar number class");

	// A separator is always the final result of its character.
	a_sep_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((result_kind == KIND_SEMI) || (result_kind == KIND_COMMA)) |->
		last_of_run)
		else $error("separator not marked as final result");

	// A word end that is not final is followed at once by its separator.
	a_end_then_sep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (result_kind == KIND_END) && !last_of_run |=>
		out_valid && ((result_kind == KIND_SEMI) || (result_kind == KIND_COMMA)))
		else $error("word end not followed by its separator");

endmodule

bind message_text_tokenizer_unit mtt_checker u_mtt_checker (.*);

FILE: tb/message_text_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message text tokenizer testbench
// Sends a stream of text bytes into the tokenizer and compares every result
// with a prediction that is worked out per transfer. It covers separators,
// whitespace, backslash escapes, floats, dollar words and a word that is cut
// at the maximum length. Both channels stall at random, with one long
// receiver hold-off and pauses that let the results drain.
// ----------------------------------------------------------------------------
module message_text_tokenizer_unit_tb;

	import mtt_pkg::*;

	typedef logic [CHAR_W-1:0] char_t;

	localparam int unsigned WORD_CAP = 1024;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 520;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_SLACK = 16;
	localparam int MAX_SHOWN = 10;
	localparam int unsigned RUN_LIMIT_NS = 12_000_000;

	// Predicts the tokens of the text seen so far and checks them in order.
	class token_tracker;
		int unsigned word_cap;
		int unsigned failures;
		result_t expected_tokens[$];
		result_t step_out[$];
		bit in_word;
		logic [NS_W-1:0] fstate;
		bit escaping;
		bit after_dollar;
		bit dollar_hit;
		bit dollar_pure;
		int unsigned dollar_value;
		int unsigned word_len;

		function new(int unsigned cap);
			word_cap = cap;
			failures = 0;
			in_word = 1'b0;
			clear_word();
		endfunction

		function bit is_numeral(char_t c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function void clear_word();
			fstate = NS_START;
			escaping = 1'b0;
			after_dollar = 1'b0;
			dollar_hit = 1'b0;
			dollar_pure = 1'b0;
			dollar_value = 0;
			word_len = 0;
		endfunction

		// Decimal float recogniser, stepped once per byte of the word.
		function logic [NS_W-1:0] next_number_state(logic [NS_W-1:0] s, char_t c);
			bit num;
			bit dot;
			bit minus;
			bit sign;
			bit expo;
			num = is_numeral(c);
			dot = (c == CH_DOT);
			minus = (c == CH_MINUS);
			sign = minus || (c == CH_PLUS);
			expo = (c == CH_E_LOW) || (c == CH_E_UP);
			case (s)
				NS_START, NS_MINUS: begin
					if (minus && s == NS_START) return NS_MINUS;
					if (num) return NS_INT;
					if (dot) return NS_LEAD_DOT;
				end
				NS_INT: begin
					if (dot) return NS_DOT;
					if (expo) return NS_EXP;
					if (num) return NS_INT;
				end
				NS_LEAD_DOT: begin
					if (num) return NS_FRAC;
				end
				NS_DOT, NS_FRAC: begin
					if (expo) return NS_EXP;
					if (num) return NS_FRAC;
				end
				NS_EXP: begin
					if (sign) return NS_EXP_SIGN;
					if (num) return NS_EXP_DIGIT;
				end
				NS_EXP_SIGN, NS_EXP_DIGIT: begin
					if (num) return NS_EXP_DIGIT;
				end
				default: begin
				end
			endcase
			return NS_ERROR;
		endfunction

		function void emit(logic [KIND_W-1:0] kind, char_t ch, logic [CLASS_W-1:0] cls,
		                   logic [INDEX_W-1:0] idx, logic [LEN_W-1:0] len);
			result_t r;
			r.kind = kind;
			r.ch = ch;
			r.cls = cls;
			r.idx = idx;
			r.len = len;
			r.last = 1'b0;
			step_out.push_back(r);
		endfunction

		// Word end: float beats dollar, dollar beats plain symbol.
		function void close_word();
			logic [CLASS_W-1:0] cls;
			logic [INDEX_W-1:0] idx;
			cls = CLS_SYMBOL;
			idx = '0;
			if (fstate inside {NS_INT, NS_DOT, NS_FRAC, NS_EXP_DIGIT}) begin
				cls = CLS_FLOAT;
			end else if (dollar_hit) begin
				if (dollar_pure) begin
					cls = CLS_DOLLAR_NUM;
					idx = dollar_value[INDEX_W-1:0];
				end else begin
					cls = CLS_DOLLAR_SYM;
				end
			end
			emit(KIND_END, '0, cls, idx, word_len[LEN_W-1:0]);
			in_word = 1'b0;
			clear_word();
		endfunction

		// Notes one accepted byte; returns 1 when the byte is merely skipped.
		function bit take_char(char_t c, bit eot);
			bit blank;
			bit sep;
			bit was_esc;
			logic [KIND_W-1:0] sep_kind;
			blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
			sep = (c == CH_SEMI) || (c == CH_COMMA);
			sep_kind = (c == CH_SEMI) ? KIND_SEMI : KIND_COMMA;
			step_out.delete();
			if (in_word && !escaping && (blank || sep)) begin
				close_word();
				if (sep) emit(sep_kind, '0, CLS_SYMBOL, '0, '0);
			end else if (!in_word && blank) begin
				return 1'b1;
			end else if (!in_word && sep) begin
				emit(sep_kind, '0, CLS_SYMBOL, '0, '0);
			end else begin
				was_esc = escaping;
				if (!in_word) begin
					clear_word();
					in_word = 1'b1;
				end
				// The backslash itself goes through the float recogniser.
				if (fstate != NS_ERROR) fstate = next_number_state(fstate, c);
				if (after_dollar && is_numeral(c)) dollar_hit = 1'b1;
				after_dollar = !was_esc && (c == CH_DOLLAR);
				if (!was_esc && c == CH_BSLASH) begin
					escaping = 1'b1;
				end else begin
					escaping = 1'b0;
					if (word_len == 0) begin
						dollar_pure = (c == CH_DOLLAR);
					end else if (dollar_pure) begin
						if (is_numeral(c)) begin
							dollar_value = dollar_value * 10 + (c - CH_ZERO);
							if (dollar_value > INDEX_MAX) dollar_value = INDEX_MAX;
						end else begin
							dollar_pure = 1'b0;
						end
					end
					word_len++;
					emit(KIND_CHAR, c, CLS_SYMBOL, '0, '0);
				end
				if (eot || word_len >= word_cap) close_word();
			end
			if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
			foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
			return 1'b0;
		endfunction

		// Compares one output transfer with the oldest predicted token.
		function void check_token(result_t got);
			result_t want;
			if (expected_tokens.size() == 0) begin
				failures++;
				if (failures <= MAX_SHOWN)
					$display("%0t: unexpected result kind %0d char %02h class %0d index %0d len %0d",
					         $time, got.kind, got.ch, got.cls, got.idx, got.len);
				return;
			end
			want = expected_tokens.pop_front();
			if (got.kind !== want.kind || got.ch !== want.ch || got.cls !== want.cls ||
			    got.idx !== want.idx || got.len !== want.len || got.last !== want.last) begin
				failures++;
				if (failures <= MAX_SHOWN) begin
					$display("%0t: mismatch, expected kind %0d char %02h class %0d index %0d len %0d last %0d",
					         $time, want.kind, want.ch, want.cls, want.idx, want.len, want.last);
					$display("%0t:           got kind %0d char %02h class %0d index %0d len %0d last %0d",
					         $time, got.kind, got.ch, got.cls, got.idx, got.len, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	char_t char_code = '0;
	logic end_of_text = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] result_kind;
	char_t char_value;
	logic [CLASS_W-1:0] word_class;
	logic [INDEX_W-1:0] dollar_index;
	logic [LEN_W-1:0] word_length;
	logic last_of_run;

	token_tracker board = new(WORD_CAP);
	int counted_items = 0;
	int send_gap_pct = 0;
	int take_stall_pct = 0;
	int hold_requests = 0;

	message_text_tokenizer_unit #(.MAX_WORD(WORD_CAP)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.char_value(char_value),
		.word_class(word_class),
		.dollar_index(dollar_index),
		.word_length(word_length),
		.last_of_run(last_of_run)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	// Idle length: none unless the pct roll hits, usually short when present, now and then long.
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic char_t rand_digit();
		return CH_ZERO + char_t'($urandom_range(0, 9));
	endfunction

	function automatic char_t rand_delim();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_CR;
			4: return CH_SEMI;
			default: return CH_COMMA;
		endcase
	endfunction

	// One random token: mostly well-formed numbers, dollar words and symbols, or a lone delimiter,
	// with some noise and broken escapes mixed in.
	function automatic void build_token(ref char_t q[$]);
		q.delete();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				if ($urandom_range(0, 2) == 0) q.push_back(CH_MINUS);
				repeat ($urandom_range(0, 3)) q.push_back(rand_digit());
				if ($urandom_range(0, 1) == 1) q.push_back(CH_DOT);
				repeat ($urandom_range(0, 3)) q.push_back(rand_digit());
				if ($urandom_range(0, 2) == 0) begin
					q.push_back($urandom_range(0, 1) == 1 ? CH_E_LOW : CH_E_UP);
					case ($urandom_range(0, 2))
						0: q.push_back(CH_PLUS);
						1: q.push_back(CH_MINUS);
						default: begin
						end
					endcase
					repeat ($urandom_range(0, 2)) q.push_back(rand_digit());
				end
				if ($urandom_range(0, 7) == 0) q.push_back(char_t'($urandom_range(0, 255)));
			end
			3, 4: begin
				if ($urandom_range(0, 4) == 0) q.push_back(char_t'($urandom_range(8'h61, 8'h7A)));
				q.push_back(CH_DOLLAR);
				repeat ($urandom_range(1, 6)) q.push_back(rand_digit());
				if ($urandom_range(0, 3) == 0) q.push_back(char_t'($urandom_range(8'h21, 8'h7E)));
			end
			5: begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 4) == 0) begin
						q.push_back(CH_BSLASH);
						q.push_back(char_t'($urandom_range(0, 255)));
					end else begin
						q.push_back(char_t'($urandom_range(8'h21, 8'h7E)));
					end
				end
			end
			6, 7: begin
				q.push_back(rand_delim());
			end
			8: begin
				repeat ($urandom_range(1, 4)) q.push_back(char_t'($urandom_range(0, 255)));
			end
			default: begin
				case ($urandom_range(0, 2))
					0: begin
						q.push_back(CH_BSLASH);
						q.push_back(rand_delim());
					end
					1: q.push_back(CH_DOLLAR);
					default: q.push_back(CH_BSLASH);
				endcase
			end
		endcase
	endfunction

	// Offers one byte and waits for its transfer; valid stays high afterwards.
	task automatic send_char(input char_t c, input bit eot);
		int gap;
		gap = pick_gap(send_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		if (!board.take_char(c, eot)) counted_items++;
	endtask

	task automatic send_bytes(input char_t q[$], input bit eot_last, input int eot_pct);
		foreach (q[i])
			send_char(q[i], (eot_last && i == q.size() - 1) || ($urandom_range(0, 99) < eot_pct));
	endtask

	task automatic send_text(input string s, input bit eot_last);
		char_t q[$];
		for (int i = 0; i < s.len(); i++) q.push_back(char_t'(s[i]));
		send_bytes(q, eot_last, 0);
	endtask

	// Stops offering and waits until every predicted token has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_tokens.size() != 0) @(posedge clk);
	endtask

	// Output side: checks each transfer and chooses the next ready value.
	initial begin : take_results
		int stall_left;
		int hold_served;
		int gap;
		result_t got;
		stall_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind = result_kind;
				got.ch = char_value;
				got.cls = word_class;
				got.idx = dollar_index;
				got.len = word_length;
				got.last = last_of_run;
				board.check_token(got);
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				gap = pick_gap(take_stall_pct);
				if (gap > 0) begin
					out_ready <= 1'b0;
					stall_left = gap - 1;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Input side: reset, directed text, random text, then one cut word.
	initial begin : stimulus
		char_t text[$];
		int phase;
		int next_switch;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Float with every sign and exponent state, ended by a semicolon.
		send_text("-.5e+7;", 1'b0);
		// Dollar symbol ended by a comma, after a skipped tab.
		send_text("\t$1x,", 1'b0);
		// Escaped semicolon starting a word, after a skipped carriage return.
		send_text("\015\\;\n", 1'b0);
		// Top byte and NUL are ordinary word bytes; the dollar is not followed by a digit.
		text = {CH_DOLLAR, 8'hFF, 8'h00, CH_SPACE};
		send_bytes(text, 1'b0, 0);
		// Dollar as the last byte of its word never counts.
		send_text("8$ ", 1'b0);
		// Float ending on a dot, closed by the end of the text.
		send_text("12.", 1'b1);
		// Lone backslash at the end of the text gives an empty word.
		send_text("\\", 1'b1);

		phase = 0;
		next_switch = 0;
		while (counted_items < RANDOM_ITEMS) begin
			if (counted_items >= next_switch) begin
				phase++;
				next_switch += 100;
				if (phase == 3) begin
					// Receiver holds off while the sender keeps pushing bytes.
					hold_requests++;
					send_gap_pct = 0;
					take_stall_pct = 0;
				end else begin
					if (phase == 5) wait_drained();
					case ($urandom_range(0, 4))
						0: begin
							send_gap_pct = 0;
							take_stall_pct = 0;
						end
						1: begin
							send_gap_pct = 20;
							take_stall_pct = 20;
						end
						2: begin
							send_gap_pct = 60;
							take_stall_pct = 50;
						end
						3: begin
							send_gap_pct = 0;
							take_stall_pct = 40;
						end
						default: begin
							send_gap_pct = 40;
							take_stall_pct = 0;
						end
					endcase
				end
			end
			build_token(text);
			if ($urandom_range(0, 9) < 7) text.push_back(rand_delim());
			send_bytes(text, $urandom_range(0, 9) == 0, 1);
		end

		// Dollar word cut at the maximum length, saturating its index; the
		// semicolon that follows is handled outside the word.
		wait_drained();
		send_gap_pct = 10;
		take_stall_pct = 10;
		text = {CH_DOLLAR};
		repeat (WORD_CAP - 1) text.push_back(rand_digit());
		text.push_back(CH_SEMI);
		send_bytes(text, 1'b0, 0);

		wait_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (board.failures == 0 && board.expected_tokens.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: message_text_tokenizer_unit.f
hdl/mtt_pkg.sv
hdl/message_text_tokenizer_unit.sv
hdl/mtt_checker.sv
tb/message_text_tokenizer_unit_tb.sv
